// ===== sv/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and constants of the masked stamp clip writer.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

    localparam int MASK_SIDE_DEF  = 256;
    localparam int IMAGE_SIDE_DEF = 4096;

    localparam int VALUE_W     = 8;
    localparam int MSIZE_W     = 9;
    localparam int CENTRE_W    = 16;
    localparam int ISIZE_W     = 13;
    localparam int COLOUR_W    = 24;
    localparam int CHAN_W      = 8;
    localparam int PIX_INDEX_W = 24;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MASK_WIDTH   = 3'd0,
        REG_MASK_HEIGHT  = 3'd1,
        REG_CENTER_X     = 3'd2,
        REG_CENTER_Y     = 3'd3,
        REG_IMAGE_WIDTH  = 3'd4,
        REG_IMAGE_HEIGHT = 3'd5,
        REG_STAMP_COLOUR = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [MSIZE_W-1:0]         mask_width;
        logic [MSIZE_W-1:0]         mask_height;
        logic signed [CENTRE_W-1:0] center_x;
        logic signed [CENTRE_W-1:0] center_y;
        logic [ISIZE_W-1:0]         image_width;
        logic [ISIZE_W-1:0]         image_height;
        logic [COLOUR_W-1:0]        stamp_colour;
    } t_cfg;

endpackage

`default_nettype wire

// ===== sv/msc_if.sv =====
// ----------------------------------------------------------------------------
// msc_if
// Request channels of the masked stamp clip writer: mask bytes in, pixel
// writes out, register writes in.
// ----------------------------------------------------------------------------
`default_nettype none

interface msc_in_if;
    logic                         valid;
    logic                         ready;
    logic [msc_pkg::VALUE_W-1:0]  mask_value;

    modport source (output valid, output mask_value, input ready);
    modport sink   (input valid, input mask_value, output ready);
endinterface

interface msc_out_if;
    logic                             valid;
    logic                             ready;
    logic [msc_pkg::PIX_INDEX_W-1:0]  pixel_index;
    logic [msc_pkg::CHAN_W-1:0]       red;
    logic [msc_pkg::CHAN_W-1:0]       green;
    logic [msc_pkg::CHAN_W-1:0]       blue;
    logic [msc_pkg::CHAN_W-1:0]       alpha;

    modport source (output valid, output pixel_index, output red, output green,
                    output blue, output alpha, input ready);
    modport sink   (input valid, input pixel_index, input red, input green,
                    input blue, input alpha, output ready);
endinterface

interface msc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [msc_pkg::CFG_INDEX_W-1:0]  index;
    logic [msc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/msc_cfg.sv =====
// ----------------------------------------------------------------------------
// msc_cfg
// Configuration register file: mask size, centre, image size and colour.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_cfg (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    msc_cfg_if.sink        i_cfg,
    output msc_pkg::t_cfg  o_cfg
);

    msc_pkg::t_cfg r_cfg;
    msc_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            case (msc_pkg::t_cfg_reg'(i_cfg.index))
                msc_pkg::REG_MASK_WIDTH: begin
                    n_cfg.mask_width = i_cfg.data[msc_pkg::MSIZE_W-1:0];
                end
                msc_pkg::REG_MASK_HEIGHT: begin
                    n_cfg.mask_height = i_cfg.data[msc_pkg::MSIZE_W-1:0];
                end
                msc_pkg::REG_CENTER_X: begin
                    n_cfg.center_x = $signed(i_cfg.data[msc_pkg::CENTRE_W-1:0]);
                end
                msc_pkg::REG_CENTER_Y: begin
                    n_cfg.center_y = $signed(i_cfg.data[msc_pkg::CENTRE_W-1:0]);
                end
                msc_pkg::REG_IMAGE_WIDTH: begin
                    n_cfg.image_width = i_cfg.data[msc_pkg::ISIZE_W-1:0];
                end
                msc_pkg::REG_IMAGE_HEIGHT: begin
                    n_cfg.image_height = i_cfg.data[msc_pkg::ISIZE_W-1:0];
                end
                msc_pkg::REG_STAMP_COLOUR: begin
                    n_cfg.stamp_colour = i_cfg.data[msc_pkg::COLOUR_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mask_width   <= msc_pkg::MSIZE_W'(1);
            r_cfg.mask_height  <= msc_pkg::MSIZE_W'(1);
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.image_width  <= msc_pkg::ISIZE_W'(1);
            r_cfg.image_height <= msc_pkg::ISIZE_W'(1);
            r_cfg.stamp_colour <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/msc_pos.sv =====
// ----------------------------------------------------------------------------
// msc_pos
// Mask column and row counters and the input register holding each byte
// with its image position.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_pos #(
    parameter int MAX_MASK_SIDE = msc_pkg::MASK_SIDE_DEF,
    parameter int PW            = 18
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    msc_in_if.sink                            i_in,
    input  wire msc_pkg::t_cfg                i_cfg,
    input  wire logic                         i_adv,
    output logic                              o_valid,
    output logic [msc_pkg::VALUE_W-1:0]       o_mask_value,
    output logic signed [PW-1:0]              o_px,
    output logic signed [PW-1:0]              o_py
);

    localparam int CW = $clog2(MAX_MASK_SIDE);
    localparam int SW = (CW + 1 > msc_pkg::MSIZE_W) ? CW + 1 : msc_pkg::MSIZE_W;

    logic [CW-1:0]               r_col;
    logic [CW-1:0]               r_row;
    logic [CW-1:0]               n_col;
    logic [CW-1:0]               n_row;
    logic                        r_valid;
    logic                        n_valid;
    logic [msc_pkg::VALUE_W-1:0] r_mv;
    logic signed [PW-1:0]        r_px;
    logic signed [PW-1:0]        r_py;
    logic [SW-1:0]               mw_raw;
    logic [SW-1:0]               mh_raw;
    logic [SW-1:0]               mw;
    logic [SW-1:0]               mh;
    logic                        accept;
    logic signed [PW-1:0]        px;
    logic signed [PW-1:0]        py;

    assign i_in.ready = i_adv;
    assign accept     = i_in.valid && i_adv;

    // clamp the mask size to 1..MAX_MASK_SIDE
    assign mw_raw = SW'(i_cfg.mask_width);
    assign mh_raw = SW'(i_cfg.mask_height);
    assign mw = (mw_raw == '0) ? SW'(1) :
                (mw_raw > SW'(MAX_MASK_SIDE)) ? SW'(MAX_MASK_SIDE) : mw_raw;
    assign mh = (mh_raw == '0) ? SW'(1) :
                (mh_raw > SW'(MAX_MASK_SIDE)) ? SW'(MAX_MASK_SIDE) : mh_raw;

    assign px = PW'(i_cfg.center_x) - $signed(PW'(mw >> 1))
                + $signed(PW'(r_col));
    assign py = PW'(i_cfg.center_y) - $signed(PW'(mh >> 1))
                + $signed(PW'(r_row));

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_valid = i_adv ? accept : r_valid;
        if (accept) begin
            if (SW'(r_col) + SW'(1) >= mw) begin
                n_col = '0;
                if (SW'(r_row) + SW'(1) >= mh) begin
                    n_row = '0;
                end else begin
                    n_row = r_row + CW'(1);
                end
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mv <= i_in.mask_value;
            r_px <= px;
            r_py <= py;
        end
    end

    assign o_valid      = r_valid;
    assign o_mask_value = r_mv;
    assign o_px         = r_px;
    assign o_py         = r_py;

endmodule

`default_nettype wire

// ===== sv/msc_pix.sv =====
// ----------------------------------------------------------------------------
// msc_pix
// Clip test, linear index and the result register of the pixel write.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_pix #(
    parameter int MAX_IMAGE_SIDE = msc_pkg::IMAGE_SIDE_DEF,
    parameter int PW             = 18
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire msc_pkg::t_cfg           i_cfg,
    input  wire logic                    i_valid,
    input  wire logic [msc_pkg::VALUE_W-1:0] i_mask_value,
    input  wire logic signed [PW-1:0]    i_px,
    input  wire logic signed [PW-1:0]    i_py,
    output logic                         o_adv,
    msc_out_if.source                    o_out
);

    localparam int IW  = $clog2(MAX_IMAGE_SIDE) + 1;
    localparam int EW  = (IW > msc_pkg::ISIZE_W) ? IW : msc_pkg::ISIZE_W;
    localparam int CPW = (PW > EW) ? PW : EW;

    logic [EW-1:0]                   iw_raw;
    logic [EW-1:0]                   ih_raw;
    logic [EW-1:0]                   iw;
    logic [EW-1:0]                   ih;
    logic                            in_image;
    logic                            hit;
    logic                            out_free;
    logic [2*EW-1:0]                 index;
    logic                            r_ovalid;
    logic [msc_pkg::PIX_INDEX_W-1:0] r_index;
    logic [msc_pkg::COLOUR_W-1:0]    r_colour;
    logic [msc_pkg::VALUE_W-1:0]     r_alpha;

    assign iw_raw = EW'(i_cfg.image_width);
    assign ih_raw = EW'(i_cfg.image_height);
    assign iw = (iw_raw > EW'(MAX_IMAGE_SIDE)) ? EW'(MAX_IMAGE_SIDE) : iw_raw;
    assign ih = (ih_raw > EW'(MAX_IMAGE_SIDE)) ? EW'(MAX_IMAGE_SIDE) : ih_raw;

    assign in_image = !i_px[PW-1] && !i_py[PW-1]
                      && (CPW'($unsigned(i_px)) < CPW'(iw))
                      && (CPW'($unsigned(i_py)) < CPW'(ih));
    assign hit      = i_valid && (i_mask_value != '0) && in_image;
    assign out_free = !r_ovalid || o_out.ready;
    assign o_adv    = !hit || out_free;

    assign index = i_py[EW-1:0] * iw + (2*EW)'(i_px[EW-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_free) begin
            r_ovalid <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && hit) begin
            r_index  <= index[msc_pkg::PIX_INDEX_W-1:0];
            r_colour <= i_cfg.stamp_colour;
            r_alpha  <= i_mask_value;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.pixel_index = r_index;
    assign o_out.red         = r_colour[23:16];
    assign o_out.green       = r_colour[15:8];
    assign o_out.blue        = r_colour[7:0];
    assign o_out.alpha       = r_alpha;

endmodule

`default_nettype wire

// ===== sv/masked_stamp_clip_writer_core.sv =====
// ----------------------------------------------------------------------------
// masked_stamp_clip_writer_core
// Stamps a streamed 8-bit mask onto an image centred at a configured point
// and issues one pixel write request for each visible nonzero mask byte.
// ----------------------------------------------------------------------------
// One mask byte is taken every cycle while the pixel side is not stalled;
// a pixel write request passes the input register, then the result
// register, and the single row-times-width multiply between them sets the
// clock. The mask column and row counters advance on every byte and wrap
// at the end of the mask. Zero bytes and positions outside the image give
// no request. Write registers only while no byte is in flight.
`default_nettype none

module masked_stamp_clip_writer_core #(
    parameter int MAX_MASK_SIDE  = msc_pkg::MASK_SIDE_DEF,
    parameter int MAX_IMAGE_SIDE = msc_pkg::IMAGE_SIDE_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msc_in_if.sink     i_in,
    msc_out_if.source  o_out,
    msc_cfg_if.sink    i_cfg
);

    localparam int CW = $clog2(MAX_MASK_SIDE);
    localparam int SW = (CW + 1 > msc_pkg::MSIZE_W) ? CW + 1 : msc_pkg::MSIZE_W;
    localparam int PW = ((SW > msc_pkg::CENTRE_W) ? SW : msc_pkg::CENTRE_W) + 2;

    msc_pkg::t_cfg               cfg;
    logic                        adv;
    logic                        s1_valid;
    logic [msc_pkg::VALUE_W-1:0] s1_mask_value;
    logic signed [PW-1:0]        s1_px;
    logic signed [PW-1:0]        s1_py;

    msc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    msc_pos #(
        .MAX_MASK_SIDE (MAX_MASK_SIDE),
        .PW            (PW)
    ) u_pos (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_cfg        (cfg),
        .i_adv        (adv),
        .o_valid      (s1_valid),
        .o_mask_value (s1_mask_value),
        .o_px         (s1_px),
        .o_py         (s1_py)
    );

    msc_pix #(
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE),
        .PW             (PW)
    ) u_pix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (s1_valid),
        .i_mask_value (s1_mask_value),
        .i_px         (s1_px),
        .i_py         (s1_py),
        .o_adv        (adv),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the masked stamp clip writer core.
// Streams mask bytes under a series of register settings, predicts every
// pixel write request from a shadow of the registers and the mask counters,
// and checks each request field by field in order, with random idling on
// both the byte and the pixel side.
// ----------------------------------------------------------------------------

module tb;
    import msc_pkg::*;

    localparam int                   CYCLE_LIMIT = 1000000;
    localparam int                   ITEM_TARGET = 1800;
    localparam int                   CALM_FROM   = 1500;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic [PIX_INDEX_W-1:0] index;
        logic [CHAN_W-1:0]      red;
        logic [CHAN_W-1:0]      green;
        logic [CHAN_W-1:0]      blue;
        logic [CHAN_W-1:0]      alpha;
    } t_pixel_write;

    logic i_clk;
    logic i_rst_n;

    msc_in_if  in_if();
    msc_out_if out_if();
    msc_cfg_if cfg_if();

    masked_stamp_clip_writer_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .i_cfg   (cfg_if.sink)
    );

    logic [MSIZE_W-1:0]         mask_w_reg;
    logic [MSIZE_W-1:0]         mask_h_reg;
    logic signed [CENTRE_W-1:0] centre_x_reg;
    logic signed [CENTRE_W-1:0] centre_y_reg;
    logic [ISIZE_W-1:0]         image_w_reg;
    logic [ISIZE_W-1:0]         image_h_reg;
    logic [COLOUR_W-1:0]        colour_reg;
    logic [7:0]                 mask_col;
    logic [7:0]                 mask_row;

    logic [VALUE_W-1:0] mask_bytes[$];
    t_pixel_write       pixel_writes[$];
    t_pixel_write       want;

    int  mismatches  = 0;
    int  cycle_count = 0;
    int  item_total  = 0;
    int  in_gap      = 0;
    int  out_gap     = 0;
    bit  in_idle_on  = 0;
    bit  out_idle_on = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        mismatches++;
        $display("%0t: %s", $time, msg);
    endtask

    function automatic void stamp_mask_byte(input logic [VALUE_W-1:0] mv);
        int mw, mh, iw, ih, px, py;
        t_pixel_write w;
        mw = mask_w_reg;
        mh = mask_h_reg;
        iw = image_w_reg;
        ih = image_h_reg;
        if (mw < 1) mw = 1;
        if (mw > MASK_SIDE_DEF) mw = MASK_SIDE_DEF;
        if (mh < 1) mh = 1;
        if (mh > MASK_SIDE_DEF) mh = MASK_SIDE_DEF;
        if (iw > IMAGE_SIDE_DEF) iw = IMAGE_SIDE_DEF;
        if (ih > IMAGE_SIDE_DEF) ih = IMAGE_SIDE_DEF;
        px = int'(centre_x_reg) - mw / 2 + int'(mask_col);
        py = int'(centre_y_reg) - mh / 2 + int'(mask_row);
        if (mv != 0 && px >= 0 && py >= 0 && px < iw && py < ih) begin
            w.index = PIX_INDEX_W'(py * iw + px);
            w.red   = colour_reg[23:16];
            w.green = colour_reg[15:8];
            w.blue  = colour_reg[7:0];
            w.alpha = mv;
            pixel_writes.push_back(w);
        end
        if (int'(mask_col) + 1 >= mw) begin
            mask_col = '0;
            if (int'(mask_row) + 1 >= mh) mask_row = '0;
            else mask_row = mask_row + 1'b1;
        end else begin
            mask_col = mask_col + 1'b1;
        end
    endfunction

    // byte side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) stamp_mask_byte(in_if.mask_value);
            if (!in_if.valid || in_if.ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    in_if.valid <= 1'b0;
                end else if (in_idle_on && $urandom_range(0, 9) == 0) begin
                    in_gap = $urandom_range(1, 19) - 1;
                    in_if.valid <= 1'b0;
                end else if (mask_bytes.size() > 0) begin
                    in_if.valid      <= 1'b1;
                    in_if.mask_value <= mask_bytes.pop_front();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // pixel side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (pixel_writes.size() == 0) begin
                    flag_error($sformatf("pixel write to %0d with none pending",
                                         out_if.pixel_index));
                end else begin
                    want = pixel_writes.pop_front();
                    if (out_if.pixel_index !== want.index)
                        flag_error($sformatf("pixel_index %0d, expected %0d",
                                             out_if.pixel_index, want.index));
                    if (out_if.red !== want.red)
                        flag_error($sformatf("red %0h, expected %0h", out_if.red, want.red));
                    if (out_if.green !== want.green)
                        flag_error($sformatf("green %0h, expected %0h",
                                             out_if.green, want.green));
                    if (out_if.blue !== want.blue)
                        flag_error($sformatf("blue %0h, expected %0h", out_if.blue, want.blue));
                    if (out_if.alpha !== want.alpha)
                        flag_error($sformatf("alpha %0h, expected %0h",
                                             out_if.alpha, want.alpha));
                end
            end
            if (out_gap > 0) begin
                out_gap--;
                out_if.ready <= 1'b0;
            end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
                out_gap = $urandom_range(1, 19) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d pixel writes pending", $time, pixel_writes.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value, input int width);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        keep = (CFG_DATA_W'(1) << width) - 1'b1;
        data = CFG_DATA_W'(value) & keep;
        if ($urandom_range(0, 3) == 0) data = data | (CFG_DATA_W'($urandom) & ~keep);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_MASK_WIDTH:   mask_w_reg   = data[MSIZE_W-1:0];
            REG_MASK_HEIGHT:  mask_h_reg   = data[MSIZE_W-1:0];
            REG_CENTER_X:     centre_x_reg = data[CENTRE_W-1:0];
            REG_CENTER_Y:     centre_y_reg = data[CENTRE_W-1:0];
            REG_IMAGE_WIDTH:  image_w_reg  = data[ISIZE_W-1:0];
            REG_IMAGE_HEIGHT: image_h_reg  = data[ISIZE_W-1:0];
            REG_STAMP_COLOUR: colour_reg   = data[COLOUR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_stamp(input int mw, input int mh, input int cx, input int cy,
                             input int iw, input int ih, input int colour);
        write_reg(REG_MASK_WIDTH, mw, MSIZE_W);
        write_reg(REG_MASK_HEIGHT, mh, MSIZE_W);
        write_reg(REG_CENTER_X, cx, CENTRE_W);
        write_reg(REG_CENTER_Y, cy, CENTRE_W);
        write_reg(REG_IMAGE_WIDTH, iw, ISIZE_W);
        write_reg(REG_IMAGE_HEIGHT, ih, ISIZE_W);
        write_reg(REG_STAMP_COLOUR, colour, COLOUR_W);
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom, CFG_DATA_W);
    endtask

    // hold until every byte is taken and every write has come out
    task automatic drain();
        while (mask_bytes.size() != 0 || in_if.valid || pixel_writes.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic int mask_side();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(257, 511);
        if (r <= 4) return $urandom_range(17, 256);
        return $urandom_range(1, 12);
    endfunction

    function automatic int image_side();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 0;
        if (r == 1) return $urandom_range(4097, 8191);
        if (r <= 3) return $urandom_range(65, 4096);
        return $urandom_range(1, 64);
    endfunction

    initial begin
        logic [VALUE_W-1:0] first_bytes[9] = '{8'd255, 8'd1, 8'd0, 8'd128, 8'd127,
                                               8'h55, 8'hAA, 8'h80, 8'h01};
        logic [VALUE_W-1:0] wrap_bytes[4]  = '{8'd200, 8'd0, 8'd99, 8'd255};
        int mw, mh, iw, ih, emw, emh, cx, cy, n;

        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.mask_value = '0;
        out_if.ready     = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;
        mask_w_reg       = 1;
        mask_h_reg       = 1;
        centre_x_reg     = 0;
        centre_y_reg     = 0;
        image_w_reg      = 1;
        image_h_reg      = 1;
        colour_reg       = 0;
        mask_col         = 0;
        mask_row         = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // clipped on top row and left column, full colour
        set_stamp(3, 3, 0, 0, 4, 4, 24'hFFFFFF);
        foreach (first_bytes[k]) mask_bytes.push_back(first_bytes[k]);
        drain();
        // zero mask sizes, oversized image
        set_stamp(0, 0, 5, 2, 8191, 8191, 0);
        mask_bytes = '{8'd255, 8'd7, 8'd0};
        drain();
        // empty image
        set_stamp(3, 3, 1, 1, 0, 5, 24'h123456);
        mask_bytes = '{8'd255, 8'd255, 8'd255};
        drain();
        // oversized mask at the far centre corners
        set_stamp(511, 511, -32768, 32767, 4096, 4096, 24'hA5C3E1);
        mask_bytes = '{8'd9, 8'd255, 8'd1};
        drain();
        // shrink the mask with the column counter past its new edge
        set_stamp(2, 2, 1, 1, 16, 16, 24'h0F0F0F);
        foreach (wrap_bytes[k]) mask_bytes.push_back(wrap_bytes[k]);
        drain();

        while (item_total < ITEM_TARGET) begin
            mw  = mask_side();
            mh  = mask_side();
            iw  = image_side();
            ih  = image_side();
            emw = (mw < 1) ? 1 : (mw > MASK_SIDE_DEF ? MASK_SIDE_DEF : mw);
            emh = (mh < 1) ? 1 : (mh > MASK_SIDE_DEF ? MASK_SIDE_DEF : mh);
            if ($urandom_range(0, 7) == 0) begin
                cx = int'($urandom_range(0, 65535)) - 32768;
                cy = int'($urandom_range(0, 65535)) - 32768;
            end else begin
                cx = int'($urandom_range(0, iw + emw)) - emw / 2;
                cy = int'($urandom_range(0, ih + emh)) - emh / 2;
            end
            set_stamp(mw, mh, cx, cy, iw, ih, $urandom);
            if (item_total >= CALM_FROM) begin
                in_idle_on  = 0;
                out_idle_on = 0;
            end else begin
                in_idle_on  = $urandom_range(0, 3) != 0;
                out_idle_on = $urandom_range(0, 3) != 0;
            end
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, 40);
            else n = emw * emh * $urandom_range(1, 3);
            if (n > 160) n = 160;
            repeat (n) begin
                if ($urandom_range(0, 9) < 4) mask_bytes.push_back('0);
                else mask_bytes.push_back(VALUE_W'($urandom_range(1, 255)));
            end
            item_total += n;
            drain();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
